// ===== hdl/chained_hash_table_insert_lookup_top_assert.svh =====
// Assertion macros for the chained hash table block.
// Used by chained_hash_table_insert_lookup_top; expects clk and rst_n in scope.
`ifndef CHAINED_HASH_TABLE_INSERT_LOOKUP_TOP_ASSERT_SVH
`define CHAINED_HASH_TABLE_INSERT_LOOKUP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define CHTIL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("chtil assertion failed");
// Check that a condition leads to a consequence in the next cycle
`define CHTIL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chtil assertion failed");
`else
`define CHTIL_ASSERT(lbl, prop)
`define CHTIL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/chtil_pkg.sv =====
// Shared types and constants of the chained hash table block.
// No dependencies; used by the interfaces, the top module and chtil_hash.
package chtil_pkg;

  localparam int ACTION_W = 1;
  localparam int NUM_W    = 20;
  localparam int COURSE_W = 16;
  localparam int GRADE_W  = 8;
  localparam int STATUS_W = 2;

  localparam int BUCKETS_DEF = 64;
  localparam int ENTRIES_DEF = 256;

  // Bits of the record number consumed per hash step
  localparam int HASH_BITS_PER_STEP = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_INSERTED = 2'd0,
    RS_FULL     = 2'd1,
    RS_FOUND    = 2'd2,
    RS_MISS     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_WALK,
    S_RESP
  } state_t;

endpackage

// ===== hdl/chtil_in_if.sv =====
// Request channel of the chained hash table block.
// Depends on chtil_pkg for field widths.
interface chtil_in_if;
  logic                            valid;
  logic                            ready;
  logic [chtil_pkg::ACTION_W-1:0]  action;
  logic [chtil_pkg::NUM_W-1:0]     student_number;
  logic [chtil_pkg::COURSE_W-1:0]  course_code;
  logic [chtil_pkg::GRADE_W-1:0]   grade;

  modport source (output valid, action, student_number, course_code, grade, input ready);
  modport sink (input valid, action, student_number, course_code, grade, output ready);
endinterface

// ===== hdl/chtil_out_if.sv =====
// Result channel of the chained hash table block.
// Depends on chtil_pkg for field widths.
interface chtil_out_if;
  logic                            valid;
  logic                            ready;
  logic [chtil_pkg::STATUS_W-1:0]  status;
  logic [chtil_pkg::GRADE_W-1:0]   grade_out;

  modport source (output valid, status, grade_out, input ready);
  modport sink (input valid, status, grade_out, output ready);
endinterface

// ===== hdl/chained_hash_table_insert_lookup_top.sv =====
// Chained hash table, insert and lookup. Depends on chtil_pkg, chtil_in_if,
// chtil_out_if, chtil_hash, chtil_ram and the assertion macro header.
// Insert: the number is hashed, the bucket head is read and the entry is linked in; a full
// pool answers RS_FULL after the hash. Lookup: the chain is walked to a match or its end;
// the pool memory read port visits one chain entry per cycle. A new request is taken only in idle.
// Reset: synchronous; a clearing pass over all BUCKETS entries empties the bucket heads.
`include "chained_hash_table_insert_lookup_top_assert.svh"

module chained_hash_table_insert_lookup_top #(
  parameter int BUCKETS = chtil_pkg::BUCKETS_DEF,
  parameter int ENTRIES = chtil_pkg::ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  chtil_in_if.sink  in_req,
  chtil_out_if.source out_rsp
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int EW    = $clog2(ENTRIES);
  localparam int UsedW = EW + 1;
  localparam int LinkW = EW + 1;
  localparam int PoolW = chtil_pkg::NUM_W + chtil_pkg::COURSE_W + chtil_pkg::GRADE_W + LinkW;

  chtil_pkg::state_t  state_r, state_nxt;
  logic [BW-1:0]      clr_idx_r, clr_idx_nxt;
  logic [UsedW-1:0]   used_cnt_r, used_cnt_nxt;
  logic [UsedW-1:0]   steps_r, steps_nxt;
  logic               out_valid_r;

  chtil_pkg::action_t               act_r;
  logic [chtil_pkg::NUM_W-1:0]      num_r;
  logic [chtil_pkg::COURSE_W-1:0]   course_r;
  logic [chtil_pkg::GRADE_W-1:0]    grade_r;
  chtil_pkg::status_t               res_status_r, res_status_nxt;
  logic [chtil_pkg::GRADE_W-1:0]    res_grade_r, res_grade_nxt;
  chtil_pkg::status_t               out_status_r;
  logic [chtil_pkg::GRADE_W-1:0]    out_grade_r;

  logic              in_ready;
  logic              out_load;
  logic              hash_start;
  logic              hash_done;
  logic [BW-1:0]     bucket;

  logic              head_we, head_re;
  logic [BW-1:0]     head_waddr;
  logic [LinkW-1:0]  head_wdata, head_rd_data;

  logic              pool_we, pool_re;
  logic [EW-1:0]     pool_raddr;
  logic [PoolW-1:0]  pool_wdata, pool_rd_data;

  logic [chtil_pkg::NUM_W-1:0]    pq_num;
  logic [chtil_pkg::COURSE_W-1:0] pq_course;
  logic [chtil_pkg::GRADE_W-1:0]  pq_grade;
  logic [LinkW-1:0]               pq_link;
  logic                           pq_match;

  chtil_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .number (in_req.student_number),
    .done   (hash_done),
    .bucket (bucket)
  );

  // Bucket heads: valid bit plus pool index of the newest entry
  chtil_ram #(.WIDTH(LinkW), .DEPTH(BUCKETS)) u_heads (
    .clk     (clk),
    .wr_en   (head_we),
    .wr_addr (head_waddr),
    .wr_data (head_wdata),
    .rd_en   (head_re),
    .rd_addr (bucket),
    .rd_data (head_rd_data)
  );

  // Entry pool: number, course, grade and link to the older entry
  chtil_ram #(.WIDTH(PoolW), .DEPTH(ENTRIES)) u_pool (
    .clk     (clk),
    .wr_en   (pool_we),
    .wr_addr (used_cnt_r[EW-1:0]),
    .wr_data (pool_wdata),
    .rd_en   (pool_re),
    .rd_addr (pool_raddr),
    .rd_data (pool_rd_data)
  );

  assign {pq_num, pq_course, pq_grade, pq_link} = pool_rd_data;
  assign pq_match   = (pq_num == num_r) && (pq_course == course_r);
  assign pool_wdata = {num_r, course_r, grade_r, head_rd_data};

  // Next state, memory accesses and result
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    used_cnt_nxt   = used_cnt_r;
    steps_nxt      = steps_r;
    res_status_nxt = res_status_r;
    res_grade_nxt  = res_grade_r;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    hash_start     = 1'b0;
    head_we        = 1'b0;
    head_re        = 1'b0;
    head_waddr     = bucket;
    head_wdata     = {1'b1, used_cnt_r[EW-1:0]};
    pool_we        = 1'b0;
    pool_re        = 1'b0;
    pool_raddr     = head_rd_data[EW-1:0];
    unique case (state_r)
      chtil_pkg::S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_idx_r;
        head_wdata = '0;
        if (clr_idx_r == BW'(BUCKETS - 1)) begin
          state_nxt = chtil_pkg::S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + BW'(1);
        end
      end
      chtil_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_req.valid) begin
          hash_start = 1'b1;
          state_nxt  = chtil_pkg::S_HASH;
        end
      end
      chtil_pkg::S_HASH: begin
        if (hash_done) begin
          if (act_r == chtil_pkg::ACT_INSERT && used_cnt_r == UsedW'(ENTRIES)) begin
            res_status_nxt = chtil_pkg::RS_FULL;
            res_grade_nxt  = '0;
            state_nxt      = chtil_pkg::S_RESP;
          end else begin
            head_re   = 1'b1;
            state_nxt = chtil_pkg::S_HEAD;
          end
        end
      end
      chtil_pkg::S_HEAD: begin
        res_grade_nxt = '0;
        if (act_r == chtil_pkg::ACT_INSERT) begin
          // Link the new entry at the head of its chain
          pool_we        = 1'b1;
          head_we        = 1'b1;
          used_cnt_nxt   = used_cnt_r + UsedW'(1);
          res_status_nxt = chtil_pkg::RS_INSERTED;
          state_nxt      = chtil_pkg::S_RESP;
        end else if (head_rd_data[EW] && (UsedW'(head_rd_data[EW-1:0]) < used_cnt_r)) begin
          pool_re   = 1'b1;
          steps_nxt = '0;
          state_nxt = chtil_pkg::S_WALK;
        end else begin
          res_status_nxt = chtil_pkg::RS_MISS;
          state_nxt      = chtil_pkg::S_RESP;
        end
      end
      chtil_pkg::S_WALK: begin
        pool_raddr = pq_link[EW-1:0];
        if (pq_match) begin
          res_status_nxt = chtil_pkg::RS_FOUND;
          res_grade_nxt  = pq_grade;
          state_nxt      = chtil_pkg::S_RESP;
        end else if (pq_link[EW] && (UsedW'(pq_link[EW-1:0]) < used_cnt_r) &&
                     ((steps_r + UsedW'(1)) < used_cnt_r)) begin
          // Advance to the older entry
          pool_re   = 1'b1;
          steps_nxt = steps_r + UsedW'(1);
        end else begin
          res_status_nxt = chtil_pkg::RS_MISS;
          res_grade_nxt  = '0;
          state_nxt      = chtil_pkg::S_RESP;
        end
      end
      chtil_pkg::S_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_load  = 1'b1;
          state_nxt = chtil_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = chtil_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chtil_pkg::S_CLEAR;
      clr_idx_r   <= '0;
      used_cnt_r  <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_idx_r  <= clr_idx_nxt;
      used_cnt_r <= used_cnt_nxt;
      steps_r    <= steps_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the request fields and the result
  always_ff @(posedge clk) begin
    if (in_req.valid && in_ready) begin
      act_r    <= chtil_pkg::action_t'(in_req.action);
      num_r    <= in_req.student_number;
      course_r <= in_req.course_code;
      grade_r  <= in_req.grade;
    end
    res_status_r <= res_status_nxt;
    res_grade_r  <= res_grade_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_grade_r  <= res_grade_r;
    end
  end

  assign in_req.ready      = in_ready;
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = out_status_r;
  assign out_rsp.grade_out = out_grade_r;

  `CHTIL_ASSERT(a_used_bound, used_cnt_r <= UsedW'(ENTRIES))
  `CHTIL_ASSERT(a_hash_done_in_hash, !hash_done || (state_r == chtil_pkg::S_HASH))
  `CHTIL_ASSERT(a_pool_wr_room, !pool_we || (used_cnt_r < UsedW'(ENTRIES)))
  `CHTIL_ASSERT_NEXT(a_insert_advances, pool_we, used_cnt_r == $past(used_cnt_r) + UsedW'(1))

endmodule

// ===== hdl/chtil_hash.sv =====
// Bucket index unit: record number modulo the bucket count, HASH_BITS_PER_STEP bits per step.
// Depends on chtil_pkg for the number width and step size.
module chtil_hash #(
  parameter int BUCKETS = chtil_pkg::BUCKETS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [chtil_pkg::NUM_W-1:0]  number,
  output logic                         done,
  output logic [$clog2(BUCKETS)-1:0]   bucket
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int Step  = chtil_pkg::HASH_BITS_PER_STEP;
  localparam int Steps = (chtil_pkg::NUM_W + Step - 1) / Step;
  localparam int ShW   = Steps * Step;
  localparam int CntW  = $clog2(Steps + 1);

  logic            busy_r;
  logic            done_r;
  logic [CntW-1:0] cnt_r;
  logic [BW-1:0]   rem_r;
  logic [ShW-1:0]  sh_r;
  logic [BW-1:0]   rem_nxt;
  logic [BW:0]     trial;

  // Restoring remainder over the next Step most significant bits
  always_comb begin
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < Step; i++) begin
      trial = {rem_nxt, sh_r[ShW-1-i]};
      if (trial >= (BW+1)'(BUCKETS)) begin
        trial = trial - (BW+1)'(BUCKETS);
      end
      rem_nxt = trial[BW-1:0];
    end
  end

  // Sequence the steps and flag completion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CntW'(1);
        if (cnt_r == CntW'(Steps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the number and hold the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      sh_r  <= ShW'(number);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_r << Step;
    end
  end

  assign done   = done_r;
  assign bucket = rem_r;

endmodule

// ===== hdl/chtil_ram.sv =====
// Single-port-write, single-port-read synchronous memory with a registered read port.
// No dependencies.
module chtil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
